FILE: rtl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	localparam int RES_NUM_W = 32;
	localparam int RES_DEN_W = 31;
endpackage

FILE: rtl/rau_front.sv
// Front end: accept an item, form raw cross products, classify zero results.
`timescale 1ns / 1ps
module rau_front #(
	parameter int OW = 16,
	parameter int RW = 2 * OW + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          operation,
	input  logic signed [OW-1:0] p_numerator,
	input  logic [OW-2:0]       p_denominator,
	input  logic signed [OW-1:0] q_numerator,
	input  logic [OW-2:0]       q_denominator,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_neg,
	output logic                out_zero,
	output logic [RW-1:0]       out_an,
	output logic [RW-1:0]       out_ad
);
	// stage 1: products
	logic                 v_s1;
	logic [1:0]           op_s1;
	logic signed [2*OW:0] pq_s1, dp_s1, dd_s1, nn_s1, dn_s1;
	// stage 2: raw fraction
	logic                 v_s2;
	logic signed [RW:0]   n_s2, d_s2;
	logic                 adv2, adv1;
	logic signed [OW-1:0] pn, qn;
	logic signed [OW:0]   pd, qd;
	logic signed [RW:0]   n_c, d_c;

	assign adv2 = !v_s2 || out_ready;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	always_comb begin
		pn = (p_denominator == '0) ? '0 : p_numerator;
		qn = (q_denominator == '0) ? '0 : q_numerator;
		pd = (p_denominator == '0) ? (OW+1)'(1) : {2'b00, p_denominator};
		qd = (q_denominator == '0) ? (OW+1)'(1) : {2'b00, q_denominator};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			op_s1 <= operation;
			pq_s1 <= (2*OW+1)'(pn * qd);
			dp_s1 <= (2*OW+1)'(pd * qn);
			dd_s1 <= (2*OW+1)'(pd * qd);
			nn_s1 <= (2*OW+1)'(pn * qn);
			dn_s1 <= (2*OW+1)'(pd * qn);
		end
		if (adv2 && v_s1) begin
			n_s2 <= n_c;
			d_s2 <= d_c;
		end
	end

	always_comb begin
		case (rau_pkg::op_t'(op_s1))
			rau_pkg::OP_ADD: begin
				n_c = (RW+1)'(pq_s1) + (RW+1)'(dp_s1);
				d_c = (RW+1)'(dd_s1);
			end
			rau_pkg::OP_SUB: begin
				n_c = (RW+1)'(pq_s1) - (RW+1)'(dp_s1);
				d_c = (RW+1)'(dd_s1);
			end
			rau_pkg::OP_MUL: begin
				n_c = (RW+1)'(nn_s1);
				d_c = (RW+1)'(dd_s1);
			end
			default: begin
				n_c = (RW+1)'(pq_s1);
				d_c = (RW+1)'(dn_s1);
			end
		endcase
	end

	assign out_valid = v_s2;
	assign out_zero  = (n_s2 == '0) || (d_s2 == '0);
	assign out_neg   = n_s2[RW] ^ d_s2[RW];
	assign out_an    = n_s2[RW] ? RW'(-n_s2) : RW'(n_s2);
	assign out_ad    = d_s2[RW] ? RW'(-d_s2) : RW'(d_s2);
endmodule

FILE: rtl/rau_queue.sv
// Short queue between front and back ends.
`timescale 1ns / 1ps
module rau_queue #(
	parameter int W = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_ready,
	output logic [W-1:0] rd_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          wr, rd;

	assign wr_ready = cnt_q != (AW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH)) else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		wr && !rd |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count slip");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> wp_q == rp_q) else $error("queue pointers apart when empty");
endmodule

FILE: rtl/rau_back.sv
// Back end: Euclidean gcd and two divisions by the gcd, one bit per cycle.
`timescale 1ns / 1ps
module rau_back #(
	parameter int RW = 33
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           in_neg,
	input  logic                           in_zero,
	input  logic [RW-1:0]                  in_an,
	input  logic [RW-1:0]                  in_ad,
	output logic                           empty,
	input  logic                           pop,
	output logic signed [rau_pkg::RES_NUM_W-1:0] result_numerator,
	output logic [rau_pkg::RES_DEN_W-1:0]  result_denominator
);
	localparam int CW = $clog2(RW + 1);
	localparam int NW = rau_pkg::RES_NUM_W;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MOD  = 6'b000010,
		S_SWAP = 6'b000100,
		S_DIVN = 6'b001000,
		S_DIVD = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t        st_q;
	logic          neg_q, full_q;
	logic [RW-1:0] an_q, ad_q, a_q, b_q, rem_q, quo_q, qn_q;
	logic [CW-1:0] cnt_q;
	logic [RW:0]   trial;
	logic [RW-1:0] src;
	logic [NW-1:0] out_num;

	assign in_ready = st_q == S_IDLE;
	assign empty = !full_q;
	// restoring step: divisor is b_q in all phases
	assign src = (st_q == S_MOD) ? a_q : ((st_q == S_DIVN) ? an_q : ad_q);
	assign trial = {rem_q, src[RW-1 - cnt_q]} - {1'b0, b_q};
	// resize the magnitude to the output width (truncating at the default RW) before applying the sign
	assign out_num = neg_q ? -(NW'(qn_q)) : NW'(qn_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			full_q <= 1'b0;
		end else begin
			if (st_q == S_DONE && (!full_q || pop)) full_q <= 1'b1;
			else if (pop && full_q) full_q <= 1'b0;
			case (st_q)
				S_IDLE: if (in_valid) begin
					neg_q <= in_neg;
					an_q <= in_an;
					ad_q <= in_ad;
					a_q <= in_an;
					b_q <= in_ad;
					rem_q <= '0;
					cnt_q <= '0;
					if (in_zero) begin
						qn_q <= '0;
						quo_q <= RW'(1);
						st_q <= S_DONE;
					end else st_q <= S_MOD;
				end
				S_MOD, S_DIVN, S_DIVD: begin
					if (!trial[RW]) rem_q <= trial[RW-1:0];
					else rem_q <= {rem_q[RW-2:0], src[RW-1 - cnt_q]};
					quo_q <= {quo_q[RW-2:0], !trial[RW]};
					if (cnt_q == CW'(RW-1)) begin
						cnt_q <= '0;
						case (st_q)
							S_MOD: st_q <= S_SWAP;
							S_DIVN: st_q <= S_DIVD;
							default: st_q <= S_DONE;
						endcase
						if (st_q == S_DIVN) qn_q <= {quo_q[RW-2:0], !trial[RW]};
					end else cnt_q <= cnt_q + 1'b1;
				end
				S_SWAP: begin
					// rem_q holds a mod b
					if (rem_q == '0) begin
						st_q <= S_DIVN;
					end else begin
						a_q <= b_q;
						b_q <= rem_q;
						st_q <= S_MOD;
					end
					rem_q <= '0;
				end
				S_DONE: if (!full_q || pop) begin
					result_numerator <= out_num;
					result_denominator <= rau_pkg::RES_DEN_W'(quo_q);
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q)) else $error("state not one-hot");
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_SWAP && rem_q != '0 |=> st_q == S_MOD && a_q == $past(b_q))
		else $error("gcd swap slip");
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_MOD |-> b_q != '0) else $error("zero divisor");
endmodule

FILE: rtl/rational_arith_unit.sv
// Top level of the rational arithmetic unit.
// Path: front-end product and raw-fraction stages, the queue, then the back
//   end; a nonzero result also takes the gcd steps and two divisions there,
//   RW = 2*OPERAND_WIDTH+1 (33 at default).
// Throughput: one item per back-end pass; the bit-serial divider sets it.
// Reset: arst_n clears pipeline valids, queue pointers and the back-end state.
`timescale 1ns / 1ps
module rational_arith_unit #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [1:0]                     operation,
	input  logic signed [OPERAND_WIDTH-1:0] p_numerator,
	input  logic [OPERAND_WIDTH-2:0]       p_denominator,
	input  logic signed [OPERAND_WIDTH-1:0] q_numerator,
	input  logic [OPERAND_WIDTH-2:0]       q_denominator,
	output logic                           empty,
	input  logic                           pop,
	output logic signed [31:0]             result_numerator,
	output logic [30:0]                    result_denominator
);
	localparam int RW = 2 * OPERAND_WIDTH + 1;
	localparam int QW = 2 * RW + 2;

	logic          f_valid, f_ready, f_neg, f_zero, b_valid, b_ready, in_ready;
	logic [RW-1:0] f_an, f_ad;
	logic [QW-1:0] q_data;

	assign full = !in_ready;

	rau_front #(.OW(OPERAND_WIDTH), .RW(RW)) u_front (
		.clk, .arst_n, .in_valid(push), .in_ready,
		.operation, .p_numerator, .p_denominator, .q_numerator, .q_denominator,
		.out_valid(f_valid), .out_ready(f_ready), .out_neg(f_neg),
		.out_zero(f_zero), .out_an(f_an), .out_ad(f_ad)
	);

	rau_queue #(.W(QW), .DEPTH(2)) u_queue (
		.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready),
		.wr_data({f_neg, f_zero, f_an, f_ad}),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(q_data)
	);

	rau_back #(.RW(RW)) u_back (
		.clk, .arst_n, .in_valid(b_valid), .in_ready(b_ready),
		.in_neg(q_data[QW-1]), .in_zero(q_data[QW-2]),
		.in_an(q_data[2*RW-1:RW]), .in_ad(q_data[RW-1:0]),
		.empty, .pop, .result_numerator, .result_denominator
	);
endmodule
